// ===== src/sha1_byte_stream_hasher_unit_assert.svh =====
// Assertion macros for the SHA-1 byte stream hasher.
`ifndef SHA1_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1BSH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA1BSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sha1bsh_pkg.sv =====
// Package with the types, constants and codes of the SHA-1 byte stream hasher.
`default_nettype none

package sha1bsh_pkg;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam int NUM_WORDS   = 5;
    localparam int LAST_ROUND  = 79;
    localparam int BLOCK_BYTES = 64;
    localparam int LEN_START   = 56;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [31:0] INIT_CHAIN [NUM_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_DIGEST
    } state_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } dig_t;

endpackage

`default_nettype wire

// ===== src/sha1_byte_stream_hasher_unit.sv =====
// SHA-1 byte stream hasher: buffering, padding, shared round unit and digest output.
//
// Each request carries one message byte to append, or a finish command. The byte
// that completes a 64-byte block starts a compression: one shared round unit runs
// the 80 rounds one per cycle, and then the add state adds the working words into
// the chaining words. A finish shifts in the padding one byte a cycle up to the end
// of the block (and through a second block when fewer than nine bytes were free),
// compresses, and then presents the five digest words one a cycle as the output
// side takes them. The block takes no request while it works.
`default_nettype none

module sha1_byte_stream_hasher_unit
    import sha1bsh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      dig_valid,
    input  wire logic dig_ready,
    output dig_t      dig
);

`include "sha1_byte_stream_hasher_unit_assert.svh"

    state_t       state_reg,  state_next;
    state_t       ret_reg,    ret_next;
    logic [6:0]   round_reg,  round_next;
    logic [6:0]   pad_cnt_reg, pad_cnt_next;
    logic [2:0]   len_idx_reg, len_idx_next;
    logic [2:0]   out_idx_reg, out_idx_next;
    logic [63:0]  bit_count_reg, bit_count_next;
    logic [31:0]  chain_reg [NUM_WORDS];
    logic [31:0]  chain_next [NUM_WORDS];
    logic [31:0]  work_reg [NUM_WORDS];
    logic [31:0]  work_next [NUM_WORDS];
    logic [511:0] blk_reg, blk_next;

    logic [5:0]   pos;
    logic [7:0]   len_byte;
    logic [31:0]  w_sched;
    logic [31:0]  w_cur;
    logic [31:0]  f_val;
    logic [31:0]  k_val;
    logic [31:0]  t_val;
    logic         cmd_fire;
    logic         dig_fire;

    assign pos       = bit_count_reg[8:3];
    assign len_byte  = bit_count_reg[{~len_idx_reg, 3'b000} +: 8];
    assign cmd_ready = (state_reg == ST_IDLE);
    assign dig_valid = (state_reg == ST_DIGEST);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign dig_fire  = dig_valid && dig_ready;

    assign dig.digest_word = chain_reg[out_idx_reg];
    assign dig.word_index  = out_idx_reg;
    assign dig.last_word   = (out_idx_reg == 3'(NUM_WORDS - 1));

    // The message schedule shares the block shift line: word 0 is the oldest.
    always_comb
    begin
        w_sched = blk_reg[511:480] ^ blk_reg[447:416] ^ blk_reg[255:224] ^ blk_reg[95:64];
        w_cur   = (round_reg < 7'd16) ? blk_reg[511:480] : {w_sched[30:0], w_sched[31]};
        if (round_reg < 7'd20)
        begin
            f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            k_val = K0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = K1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                  | (work_reg[2] & work_reg[3]);
            k_val = K2;
        end
        else
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = K3;
        end
        t_val = {work_reg[0][26:0], work_reg[0][31:27]} + f_val + work_reg[4] + k_val + w_cur;
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        round_next     = round_reg;
        pad_cnt_next   = pad_cnt_reg;
        len_idx_next   = len_idx_reg;
        out_idx_next   = out_idx_reg;
        bit_count_next = bit_count_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        blk_next       = blk_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.command == CMD_APPEND)
                    begin
                        blk_next       = {blk_reg[503:0], cmd.data_byte};
                        bit_count_next = bit_count_reg + 64'd8;
                        if (pos == 6'(BLOCK_BYTES - 1))
                        begin
                            state_next = ST_ROUND;
                            ret_next   = ST_IDLE;
                            round_next = '0;
                            work_next  = chain_reg;
                        end
                    end
                    else
                    begin
                        blk_next     = {blk_reg[503:0], PAD_MARK};
                        pad_cnt_next = {1'b0, pos} + 7'd1;
                        state_next   = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_ZERO:
            begin
                if (pad_cnt_reg == 7'(BLOCK_BYTES))
                begin
                    state_next   = ST_ROUND;
                    ret_next     = ST_PAD_ZERO;
                    round_next   = '0;
                    work_next    = chain_reg;
                    pad_cnt_next = '0;
                end
                else if (pad_cnt_reg == 7'(LEN_START))
                begin
                    state_next   = ST_PAD_LEN;
                    len_idx_next = '0;
                end
                else
                begin
                    blk_next     = {blk_reg[503:0], 8'h00};
                    pad_cnt_next = pad_cnt_reg + 7'd1;
                end
            end
            ST_PAD_LEN:
            begin
                blk_next     = {blk_reg[503:0], len_byte};
                len_idx_next = len_idx_reg + 3'd1;
                if (len_idx_reg == 3'd7)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_DIGEST;
                    round_next = '0;
                    work_next  = chain_reg;
                end
            end
            ST_ROUND:
            begin
                work_next[0] = t_val;
                work_next[1] = work_reg[0];
                work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
                work_next[3] = work_reg[2];
                work_next[4] = work_reg[3];
                blk_next     = {blk_reg[479:0], w_cur};
                if (round_reg == 7'(LAST_ROUND))
                begin
                    round_next = '0;
                    state_next = ST_ADD;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                out_idx_next = '0;
                state_next   = ret_reg;
            end
            ST_DIGEST:
            begin
                if (dig_fire)
                begin
                    if (out_idx_reg == 3'(NUM_WORDS - 1))
                    begin
                        out_idx_next   = '0;
                        chain_next     = INIT_CHAIN;
                        bit_count_next = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            round_reg     <= '0;
            pad_cnt_reg   <= '0;
            len_idx_reg   <= '0;
            out_idx_reg   <= '0;
            bit_count_reg <= '0;
            chain_reg     <= INIT_CHAIN;
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                work_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            round_reg     <= round_next;
            pad_cnt_reg   <= pad_cnt_next;
            len_idx_reg   <= len_idx_next;
            out_idx_reg   <= out_idx_next;
            bit_count_reg <= bit_count_next;
            chain_reg     <= chain_next;
            work_reg      <= work_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    `SHA1BSH_ASSERT_NOW(a_ready_excludes_digest, cmd_ready, !dig_valid,
        "request side ready while a digest word is shown")
    `SHA1BSH_ASSERT_NOW(a_round_in_range, state_reg == ST_ROUND,
        round_reg <= 7'(LAST_ROUND), "round counter beyond the last round")
    `SHA1BSH_ASSERT_NEXT(a_finish_blocks, cmd_fire && (cmd.command == CMD_FINISH),
        !cmd_ready && (bit_count_reg == $past(bit_count_reg)),
        "finish request did not start padding")
    `SHA1BSH_ASSERT_NEXT(a_restart_after_digest, dig_fire && dig.last_word,
        cmd_ready && (bit_count_reg == 64'd0) && (chain_reg[0] == INIT_CHAIN[0]),
        "hasher not returned to its initial state after the digest")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the SHA-1 byte stream hasher with its own digest predictor.
`default_nettype none

module testbench
    import sha1bsh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEM_TARGET    = 270;
    localparam int DRAIN_CYCLES   = 100;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic dig_valid;
    logic dig_ready;
    dig_t dig;

    logic [31:0] chain_h [NUM_WORDS];
    logic [63:0] msg_bits;
    logic [7:0]  blk_bytes [BLOCK_BYTES];
    dig_t        digest_q [$];
    dig_t        due;

    int mismatch_count = 0;
    int items_sent     = 0;
    int words_checked  = 0;
    int messages_done  = 0;
    int spill_count    = 0;
    int cmd_gap_pct    = 0;
    int dig_stall_pct  = 0;
    int dig_hold_req   = 0;

    sha1_byte_stream_hasher_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .dig_valid (dig_valid),
        .dig_ready (dig_ready),
        .dig       (dig)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void load_initial_chain();
        for (int i = 0; i < NUM_WORDS; i++)
            chain_h[i] = INIT_CHAIN[i];
        msg_bits = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int s;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++)
        begin
            s = r % 16;
            if (r >= 16)
                w[s] = rotl(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rotl(a, 5) + f + e + k + w[s];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void hash_request(input cmd_t c);
        int   pos;
        dig_t dw;
        pos = int'(msg_bits[8:3]);
        if (c.command == CMD_APPEND)
        begin
            blk_bytes[pos] = c.data_byte;
            msg_bits += 64'd8;
            if (pos == BLOCK_BYTES - 1)
                sha1_compress();
        end
        else
        begin
            blk_bytes[pos] = PAD_MARK;
            for (int i = pos + 1; i < BLOCK_BYTES; i++)
                blk_bytes[i] = 8'h00;
            if (pos >= LEN_START)
            begin
                spill_count++;
                sha1_compress();
                for (int i = 0; i < LEN_START; i++)
                    blk_bytes[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                blk_bytes[LEN_START + i] = msg_bits[63 - 8*i -: 8];
            sha1_compress();
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                dw.digest_word = chain_h[i];
                dw.word_index  = 3'(i);
                dw.last_word   = (i == NUM_WORDS - 1);
                digest_q.push_back(dw);
            end
            messages_done++;
            load_initial_chain();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    task automatic send_request(input logic command, input logic [7:0] data_byte);
        cmd_t c;
        c.command   = command;
        c.data_byte = data_byte;
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        hash_request(c);
        items_sent++;
        if (cmd_gap_pct != 0 && $urandom_range(99) < cmd_gap_pct)
        begin
            cmd_valid <= 1'b0;
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(10, 40)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_request(CMD_APPEND, 8'($urandom));
        send_request(CMD_FINISH, 8'($urandom));
    endtask

    task automatic wait_digests_drained();
        cmd_valid <= 1'b0;
        wait (digest_q.size() == 0);
        @(posedge clk);
    endtask

    task automatic test_empty_message();
        send_request(CMD_FINISH, 8'hff);
        send_request(CMD_FINISH, 8'h00);
    endtask

    task automatic test_byte_extremes();
        logic [7:0] pattern [7] = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'haa, 8'h55};
        foreach (pattern[i])
            send_request(CMD_APPEND, pattern[i]);
        send_request(CMD_FINISH, 8'h5a);
        send_request(CMD_APPEND, 8'h61);
        send_request(CMD_APPEND, 8'h62);
        send_request(CMD_APPEND, 8'h63);
        send_request(CMD_FINISH, 8'ha5);
    endtask

    task automatic test_output_backpressure();
        // The receiver holds off while several short messages are offered.
        dig_hold_req = HOLD_CYCLES;
        for (int m = 0; m < 3; m++)
            send_message(2);
    endtask

    task automatic test_pause_for_digest();
        send_message(5);
        wait_digests_drained();
        send_message(3);
    endtask

    task automatic test_back_to_back();
        cmd_gap_pct   = 0;
        dig_stall_pct = 0;
        send_message(LEN_START);
        send_message(BLOCK_BYTES);
        cmd_gap_pct   = 30;
        dig_stall_pct = 30;
    endtask

    task automatic test_random_messages();
        int pad_edges [5] = '{54, 55, 56, 63, 64};
        int len;
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(9) < 6)
                len = $urandom_range(0, 8);
            else
                len = pad_edges[$urandom_range(0, 4)];
            send_message(len);
            if ($urandom_range(7) == 0)
                wait_digests_drained();
        end
    endtask

    initial
    begin
        dig_ready <= 1'b0;
        forever
        begin : receiver
            int stall_left;
            @(posedge clk);
            if (dig_hold_req != 0)
            begin
                stall_left   = dig_hold_req;
                dig_hold_req = 0;
            end
            else if (stall_left == 0 && $urandom_range(99) < dig_stall_pct)
            begin
                if ($urandom_range(9) == 0)
                    stall_left = $urandom_range(20, 60);
                else
                    stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                dig_ready <= 1'b0;
                stall_left--;
            end
            else
                dig_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dig_valid && dig_ready)
        begin
            if (digest_q.size() == 0)
                report_mismatch("digest word with nothing expected", dig.digest_word, '0);
            else
            begin
                due = digest_q.pop_front();
                words_checked++;
                if (dig.digest_word !== due.digest_word)
                    report_mismatch("digest_word", dig.digest_word, due.digest_word);
                if (dig.word_index !== due.word_index)
                    report_mismatch("word_index", 32'(dig.word_index), 32'(due.word_index));
                if (dig.last_word !== due.last_word)
                    report_mismatch("last_word", 32'(dig.last_word), 32'(due.last_word));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_valid && cmd_ready) || (dig_valid && dig_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout after %0d quiet cycles, %0d digest words outstanding",
                 quiet, digest_q.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        load_initial_chain();
        foreach (blk_bytes[i])
            blk_bytes[i] = 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cmd_gap_pct   = 30;
        dig_stall_pct = 30;

        test_empty_message();
        test_byte_extremes();
        test_output_backpressure();
        test_pause_for_digest();
        test_back_to_back();
        test_random_messages();

        wait_digests_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (digest_q.size() != 0)
            report_mismatch("digest words never delivered", 32'(digest_q.size()), '0);

        $display("Hashed %0d messages from %0d requests and checked %0d digest words.",
                 messages_done, items_sent, words_checked);
        $display("Padding spilled into a second block in %0d messages.", spill_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/sha1bsh_pkg.sv
src/sha1_byte_stream_hasher_unit.sv
bench/testbench.sv
